// ----- src/dwpi_pkg.sv -----
package dwpi_pkg;

  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StIdle    = 4'd0;
  localparam step_t StMulSpd  = 4'd1;
  localparam step_t StSpeed   = 4'd2;
  localparam step_t StErr     = 4'd3;
  localparam step_t StMulI    = 4'd4;
  localparam step_t StMulP    = 4'd5;
  localparam step_t StAdd     = 4'd6;
  localparam step_t StAcc     = 4'd7;
  localparam step_t StMag     = 4'd8;
  localparam step_t StMulPwm  = 4'd9;
  localparam step_t StDivInit = 4'd10;
  localparam step_t StDivStep = 4'd11;
  localparam step_t StPwm     = 4'd12;
  localparam step_t StOut     = 4'd13;

  typedef enum logic [3:0] {
    OP_IDLE, OP_MUL_SPD, OP_SPEED, OP_ERR, OP_MUL_I, OP_MUL_P, OP_ADD,
    OP_ACC, OP_MAG, OP_MUL_PWM, OP_DIV_INIT, OP_DIV_STEP, OP_PWM, OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_IN_VALID, C_DIV_LAST, C_WHEEL_LEFT, C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic wheel_left;
    logic out_free;
  } status_t;

  typedef enum logic [2:0] {
    CFG_KP       = 3'd0,
    CFG_KI       = 3'd1,
    CFG_SCALE    = 3'd2,
    CFG_LLIMIT   = 3'd3,
    CFG_RLIMIT   = 3'd4,
    CFG_MAX_PWM  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP     = 2'd0,
    DIR_FWD      = 2'd1,
    DIR_REV      = 2'd2,
    DIR_ALT_STOP = 2'd3
  } dir_e;

  localparam logic [15:0] KpReset     = 16'd256;
  localparam logic [15:0] KiReset     = 16'd256;
  localparam logic [17:0] ScaleReset  = 18'd135110;
  localparam logic [23:0] LimitReset  = 24'd256000;
  localparam logic [15:0] MaxPwmReset = 16'd1000;

  localparam logic signed [24:0] S25Max = 25'sh0FFFFFF;
  localparam logic signed [24:0] S25Min = -25'sh1000000;

  function automatic uword_t ustep(op_e op, step_t nxt);
    return uword_t'{op: op, cond: C_ALWAYS, tgt_t: nxt, tgt_f: nxt};
  endfunction

  function automatic uword_t prog_rom(step_t s);
    uword_t w;
    unique case (s)
      StIdle:    w = uword_t'{op: OP_IDLE, cond: C_IN_VALID, tgt_t: StMulSpd, tgt_f: StIdle};
      StMulSpd:  w = ustep(OP_MUL_SPD, StSpeed);
      StSpeed:   w = ustep(OP_SPEED, StErr);
      StErr:     w = ustep(OP_ERR, StMulI);
      StMulI:    w = ustep(OP_MUL_I, StMulP);
      StMulP:    w = ustep(OP_MUL_P, StAdd);
      StAdd:     w = ustep(OP_ADD, StAcc);
      StAcc:     w = ustep(OP_ACC, StMag);
      StMag:     w = ustep(OP_MAG, StMulPwm);
      StMulPwm:  w = ustep(OP_MUL_PWM, StDivInit);
      StDivInit: w = ustep(OP_DIV_INIT, StDivStep);
      StDivStep: w = uword_t'{op: OP_DIV_STEP, cond: C_DIV_LAST, tgt_t: StPwm,
                              tgt_f: StDivStep};
      StPwm:     w = uword_t'{op: OP_PWM, cond: C_WHEEL_LEFT, tgt_t: StMulSpd,
                              tgt_f: StOut};
      StOut:     w = uword_t'{op: OP_OUT, cond: C_OUT_FREE, tgt_t: StIdle, tgt_f: StOut};
      default:   w = ustep(OP_IDLE, StIdle);
    endcase
    return w;
  endfunction

endpackage

// ----- src/dwpi_seq.sv -----
module dwpi_seq import dwpi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t stat_i,
  output uword_t  ctrl_o
);

  step_t  step_q, step_d;
  uword_t uw;
  logic   take;

  assign uw = prog_rom(step_q);
  assign ctrl_o = uw;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:     take = 1'b1;
      C_IN_VALID:   take = stat_i.in_valid;
      C_DIV_LAST:   take = stat_i.div_last;
      C_WHEEL_LEFT: take = stat_i.wheel_left;
      C_OUT_FREE:   take = stat_i.out_free;
      default:      take = 1'b1;
    endcase
    step_d = take ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- src/dual_wheel_incremental_pi_speed_loop.sv -----
// Two-wheel incremental PI speed controller.
// Input channel (in_valid_i / in_stall_o): one item per control tick with both
// encoder counts, target speeds (signed Q.8) and direction codes.
// Output channel (out_valid_o / out_stall_i): one result item per input item
// with PWM compare values, bridge drive codes and measured speeds.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data, always
// ready; write only while no item is in flight.
// A microcode sequencer steps one shared multiplier and a radix-2 divider
// through the left wheel, then the right wheel. Each wheel takes 11 datapath
// steps plus 16 divider iterations; the result is registered in the output
// step after the right wheel, and a new item is taken only once the sequencer
// is back in its idle step. The divider iterations dominate each item's time.
// The output register lets the sequencer work on the next item while a result
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds in its output step until the register frees.
// Reset clears both wheels' accumulators and previous errors, restores the
// default configuration and empties the output register.
module dual_wheel_incremental_pi_speed_loop import dwpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] left_count_i,
  input  logic signed [15:0] right_raw_count_i,
  input  logic signed [24:0] left_target_i,
  input  logic signed [24:0] right_target_i,
  input  logic [1:0]         left_dir_i,
  input  logic [1:0]         right_dir_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        left_pwm_o,
  output logic [15:0]        right_pwm_o,
  output logic [1:0]         left_drive_o,
  output logic [1:0]         right_drive_o,
  output logic signed [24:0] left_speed_o,
  output logic signed [24:0] right_speed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  function automatic logic signed [24:0] sat25(input logic signed [42:0] x);
    logic signed [24:0] r;
    if (x > 43'(S25Max)) r = S25Max;
    else if (x < 43'(S25Min)) r = S25Min;
    else r = x[24:0];
    return r;
  endfunction

  function automatic logic is_run(input logic [1:0] d);
    return (d == DIR_FWD) || (d == DIR_REV);
  endfunction

  uword_t  ctrl;
  status_t stat;

  logic [15:0] kp_q, ki_q, max_pwm_q;
  logic [17:0] scale_q;
  logic [23:0] llim_q, rlim_q;

  logic signed [15:0] pulse_q [2];
  logic signed [24:0] tgt_q   [2];
  logic [1:0]         dir_q   [2];
  logic signed [24:0] prev_q  [2];
  logic signed [24:0] acc_q   [2];
  logic signed [24:0] spd_q   [2];
  logic [15:0]        pwm_q   [2];

  logic               wheel_q;
  logic signed [24:0] err_q;
  logic signed [25:0] diff_q;
  logic signed [42:0] prod_q, sum_q;
  logic [23:0]        mag_q, rem_q;
  logic [15:0]        quo_q;
  logic [3:0]         cnt_q;
  logic               out_valid_q;

  logic signed [25:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [44:0] mul_full;
  logic [23:0]        lim_cur;
  logic signed [25:0] err_raw;
  logic signed [43:0] acc_sum, lim_s;
  logic signed [24:0] acc_new;
  logic [24:0]        trial;
  logic               div_ge;
  logic               accept, out_free;

  dwpi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_stall_o  = (ctrl.op != OP_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  assign stat.in_valid   = in_valid_i;
  assign stat.div_last   = (cnt_q == 4'd0);
  assign stat.wheel_left = !wheel_q;
  assign stat.out_free   = out_free;

  assign lim_cur = wheel_q ? rlim_q : llim_q;

  always_comb begin
    unique case (ctrl.op)
      OP_MUL_SPD: begin
        mul_a = 26'(pulse_q[wheel_q]);
        mul_b = signed'({1'b0, scale_q});
      end
      OP_MUL_I: begin
        mul_a = 26'(err_q);
        mul_b = signed'({3'b0, ki_q});
      end
      OP_MUL_P: begin
        mul_a = diff_q;
        mul_b = signed'({3'b0, kp_q});
      end
      OP_MUL_PWM: begin
        mul_a = signed'({2'b0, mag_q});
        mul_b = signed'({3'b0, max_pwm_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign err_raw = 26'(tgt_q[wheel_q]) - 26'(spd_q[wheel_q]);

  assign acc_sum = 44'(acc_q[wheel_q]) + 44'(sum_q >>> 8);
  assign lim_s   = signed'({20'd0, lim_cur});

  always_comb begin
    priority if (acc_sum > lim_s) begin
      acc_new = lim_s[24:0];
    end else if (acc_sum < -lim_s) begin
      acc_new = 25'(-lim_s);
    end else begin
      acc_new = acc_sum[24:0];
    end
  end

  assign trial  = {rem_q, quo_q[15]};
  assign div_ge = trial >= {1'b0, lim_cur};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= KpReset;
      ki_q      <= KiReset;
      scale_q   <= ScaleReset;
      llim_q    <= LimitReset;
      rlim_q    <= LimitReset;
      max_pwm_q <= MaxPwmReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KP:      kp_q      <= cfg_data_i[15:0];
        CFG_KI:      ki_q      <= cfg_data_i[15:0];
        CFG_SCALE:   scale_q   <= cfg_data_i[17:0];
        CFG_LLIMIT:  llim_q    <= cfg_data_i;
        CFG_RLIMIT:  rlim_q    <= cfg_data_i;
        CFG_MAX_PWM: max_pwm_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
    end else begin
      if (ctrl.op == OP_SPEED && !is_run(dir_q[wheel_q])) begin
        prev_q[wheel_q] <= '0;
        acc_q[wheel_q]  <= '0;
      end
      if (ctrl.op == OP_ACC) begin
        acc_q[wheel_q]  <= acc_new;
        prev_q[wheel_q] <= err_q;
      end
      if (ctrl.op == OP_PWM) begin
        wheel_q <= ~wheel_q;
      end
      if (ctrl.op == OP_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulse_q[0] <= left_count_i;
      pulse_q[1] <= 16'(~right_raw_count_i + 16'sd1);
      tgt_q[0]   <= left_target_i;
      tgt_q[1]   <= right_target_i;
      dir_q[0]   <= left_dir_i;
      dir_q[1]   <= right_dir_i;
    end
    unique case (ctrl.op)
      OP_MUL_SPD: prod_q <= mul_full[42:0];
      OP_SPEED:   spd_q[wheel_q] <= sat25(prod_q >>> 8);
      OP_ERR:     err_q <= sat25(43'(err_raw));
      OP_MUL_I: begin
        prod_q <= mul_full[42:0];
        diff_q <= 26'(err_q) - 26'(prev_q[wheel_q]);
      end
      OP_MUL_P: begin
        sum_q  <= prod_q;
        prod_q <= mul_full[42:0];
      end
      OP_ADD:     sum_q <= sum_q + prod_q;
      OP_MAG:     mag_q <= acc_q[wheel_q][24] ? 24'(-acc_q[wheel_q]) : acc_q[wheel_q][23:0];
      OP_MUL_PWM: prod_q <= mul_full[42:0];
      OP_DIV_INIT: begin
        rem_q <= prod_q[39:16];
        quo_q <= prod_q[15:0];
        cnt_q <= '1;
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? 24'(trial - {1'b0, lim_cur}) : trial[23:0];
        quo_q <= {quo_q[14:0], div_ge};
        cnt_q <= cnt_q - 4'd1;
      end
      OP_PWM:     pwm_q[wheel_q] <= (lim_cur == 24'd0) ? 16'd0 : quo_q;
      OP_OUT: begin
        if (out_free) begin
          left_pwm_o    <= pwm_q[0];
          right_pwm_o   <= pwm_q[1];
          left_drive_o  <= is_run(dir_q[0]) ? dir_q[0] : DIR_STOP;
          right_drive_o <= is_run(dir_q[1]) ? dir_q[1] : DIR_STOP;
          left_speed_o  <= spd_q[0];
          right_speed_o <= spd_q[1];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/dwpi_chk.sv -----
module dwpi_chk import dwpi_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        left_pwm_o,
  input logic [15:0]        right_pwm_o,
  input logic [1:0]         left_drive_o,
  input logic [1:0]         right_drive_o,
  input logic signed [24:0] left_speed_o,
  input logic signed [24:0] right_speed_o
);

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in progress");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared right after accept");

  a_drive_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_drive_o != DIR_ALT_STOP) && (right_drive_o != DIR_ALT_STOP))
    else $error("invalid drive code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(left_pwm_o) && $stable(right_pwm_o) &&
      $stable(left_drive_o) && $stable(right_drive_o) &&
      $stable(left_speed_o) && $stable(right_speed_o)))
    else $error("output item changed under stall");

endmodule

bind dual_wheel_incremental_pi_speed_loop dwpi_chk u_dwpi_chk (.*);

// ----- tb/sv/dual_wheel_incremental_pi_speed_loop_test.sv -----
`timescale 1ns / 1ps
module dual_wheel_incremental_pi_speed_loop_test;
  import dwpi_pkg::*;

  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 64;
  localparam int ItemsPerSet = 219;
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  typedef struct {
    logic [15:0]        left_pwm;
    logic [15:0]        right_pwm;
    logic [1:0]         left_drive;
    logic [1:0]         right_drive;
    logic signed [24:0] left_speed;
    logic signed [24:0] right_speed;
  } tick_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] left_count;
  logic signed [15:0] right_raw_count;
  logic signed [24:0] left_target;
  logic signed [24:0] right_target;
  logic [1:0]         left_dir;
  logic [1:0]         right_dir;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        left_pwm;
  logic [15:0]        right_pwm;
  logic [1:0]         left_drive;
  logic [1:0]         right_drive;
  logic signed [24:0] left_speed;
  logic signed [24:0] right_speed;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;

  // controller state as predicted, index 0 left, 1 right
  longint kp, ki, scale, pwm_max;
  longint wheel_limit [2];
  longint prev_err [2];
  longint accum [2];

  tick_result_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  dual_wheel_incremental_pi_speed_loop dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .left_count_i      (left_count),
    .right_raw_count_i (right_raw_count),
    .left_target_i     (left_target),
    .right_target_i    (right_target),
    .left_dir_i        (left_dir),
    .right_dir_i       (right_dir),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .left_pwm_o        (left_pwm),
    .right_pwm_o       (right_pwm),
    .left_drive_o      (left_drive),
    .right_drive_o     (right_drive),
    .left_speed_o      (left_speed),
    .right_speed_o     (right_speed),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint sat25(longint x);
    if (x > longint'(S25Max)) return longint'(S25Max);
    if (x < longint'(S25Min)) return longint'(S25Min);
    return x;
  endfunction

  function automatic void wheel_update(int w, longint pulses, longint target,
                                       logic [1:0] dir, output logic [15:0] pwm,
                                       output logic [1:0] drive,
                                       output logic signed [24:0] speed);
    longint spd, e, acc, mag;
    spd = sat25((pulses * scale) >>> 8);
    if (dir == DIR_FWD || dir == DIR_REV) begin
      drive = dir;
    end else begin
      drive = DIR_STOP;
      prev_err[w] = 0;
      accum[w] = 0;
    end
    e = sat25(target - spd);
    acc = accum[w] + ((kp * (e - prev_err[w]) + ki * e) >>> 8);
    if (acc > wheel_limit[w]) acc = wheel_limit[w];
    if (acc < -wheel_limit[w]) acc = -wheel_limit[w];
    accum[w] = acc;
    prev_err[w] = e;
    mag = (acc < 0) ? -acc : acc;
    pwm = (wheel_limit[w] != 0) ? 16'((mag * pwm_max) / wheel_limit[w]) : 16'd0;
    speed = 25'(spd);
  endfunction

  function automatic tick_result_t predict_tick(
      logic signed [15:0] lc, logic signed [15:0] rc_raw,
      logic signed [24:0] lt, logic signed [24:0] rt,
      logic [1:0] ld, logic [1:0] rd);
    tick_result_t r;
    logic signed [15:0] rc;
    rc = -rc_raw;
    wheel_update(0, longint'(lc), longint'(lt), ld, r.left_pwm, r.left_drive,
                 r.left_speed);
    wheel_update(1, longint'(rc), longint'(rt), rd, r.right_pwm, r.right_drive,
                 r.right_speed);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with no item pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("left_pwm", want.left_pwm, left_pwm);
        check_field("right_pwm", want.right_pwm, right_pwm);
        check_field("left_drive", want.left_drive, left_drive);
        check_field("right_drive", want.right_drive, right_drive);
        check_field("left_speed", want.left_speed, left_speed);
        check_field("right_speed", want.right_speed, right_speed);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KP:      kp = data[15:0];
      CFG_KI:      ki = data[15:0];
      CFG_SCALE:   scale = data[17:0];
      CFG_LLIMIT:  wheel_limit[0] = data;
      CFG_RLIMIT:  wheel_limit[1] = data;
      CFG_MAX_PWM: pwm_max = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick(input logic signed [15:0] lc, input logic signed [15:0] rc,
                           input logic signed [24:0] lt, input logic signed [24:0] rt,
                           input logic [1:0] ld, input logic [1:0] rd);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    left_count      = lc;
    right_raw_count = rc;
    left_target     = lt;
    right_target    = rt;
    left_dir        = ld;
    right_dir       = rd;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_tick(lc, rc, lt, rt, ld, rd));
  endtask

  task automatic load_defaults();
    write_reg(CFG_KP, 24'(KpReset));
    write_reg(CFG_KI, 24'(KiReset));
    write_reg(CFG_SCALE, 24'(ScaleReset));
    write_reg(CFG_LLIMIT, LimitReset);
    write_reg(CFG_RLIMIT, LimitReset);
    write_reg(CFG_MAX_PWM, 24'(MaxPwmReset));
  endtask

  function automatic int unsigned pick_reg(int unsigned lo, int unsigned hi,
                                           int unsigned typ);
    int unsigned top, bot;
    top = (typ * 2 > hi) ? hi : typ * 2;
    bot = (typ / 2 < lo) ? lo : typ / 2;
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      2, 3:    return $urandom_range(hi, lo);
      default: return $urandom_range(top, bot);
    endcase
  endfunction

  task automatic randomize_config();
    write_reg(CFG_KP, {8'($urandom), 16'(pick_reg(0, 65535, 256))});
    write_reg(CFG_KI, {8'($urandom), 16'(pick_reg(0, 65535, 256))});
    write_reg(CFG_SCALE, {6'($urandom), 18'(pick_reg(0, 262143, 135110))});
    write_reg(CFG_LLIMIT, 24'(pick_reg(1, 16777215, 256000)));
    write_reg(CFG_RLIMIT, 24'(pick_reg(1, 16777215, 256000)));
    write_reg(CFG_MAX_PWM, {8'($urandom), 16'(pick_reg(0, 65535, 1000))});
  endtask

  function automatic logic signed [15:0] rand_count();
    case ($urandom_range(19))
      0:          return 16'sh8000;
      1:          return 16'sh7FFF;
      2:          return 16'sh0000;
      3, 4, 5:    return 16'($urandom);
      default:    return 16'($urandom_range(1200)) - 16'd600;
    endcase
  endfunction

  function automatic logic signed [24:0] rand_target();
    case ($urandom_range(19))
      0:          return S25Min;
      1:          return S25Max;
      2, 3, 4:    return 25'($urandom);
      default:    return 25'($urandom_range(600000)) - 25'd300000;
    endcase
  endfunction

  function automatic logic [1:0] rand_dir();
    if ($urandom_range(9) < 8) return $urandom_range(1) ? DIR_FWD : DIR_REV;
    return $urandom_range(1) ? DIR_STOP : DIR_ALT_STOP;
  endfunction

  task automatic test_defaults();
    send_tick(16'sd0, 16'sd0, 25'sd0, 25'sd0, DIR_STOP, DIR_STOP);
    send_tick(16'sd100, -16'sd100, 25'sd200000, 25'sd200000, DIR_FWD, DIR_FWD);
    send_tick(16'sh7FFF, 16'sh8000, S25Max, S25Min, DIR_FWD, DIR_REV);
    send_tick(16'sh8000, 16'sh7FFF, S25Min, S25Max, DIR_REV, DIR_FWD);
    send_tick(16'sh5555, 16'shAAAA, 25'sh0AAAAAA, -25'sh0555555, DIR_ALT_STOP, DIR_REV);
    send_tick(-16'sd1, 16'sd1, -25'sd1, 25'sd1, DIR_REV, DIR_ALT_STOP);
  endtask

  // full-scale registers drive speed and error into saturation
  task automatic test_saturation();
    drain();
    write_reg(CFG_KP, 24'hFFFFFF);
    write_reg(CFG_KI, 24'hFFFFFF);
    write_reg(CFG_SCALE, 24'hFFFFFF);
    write_reg(CFG_LLIMIT, 24'hFFFFFF);
    write_reg(CFG_RLIMIT, 24'hFFFFFF);
    write_reg(CFG_MAX_PWM, 24'hFFFFFF);
    write_reg(CfgSpareLo, 24'h123456);
    write_reg(CfgSpareHi, 24'hFFFFFF);
    send_tick(16'sh8000, 16'sh8000, S25Max, S25Min, DIR_FWD, DIR_FWD);
    send_tick(16'sh7FFF, 16'sh7FFF, S25Min, S25Max, DIR_REV, DIR_REV);
    send_tick(16'sh8000, 16'sh7FFF, S25Max, S25Max, DIR_FWD, DIR_REV);
    send_tick(16'sh7FFF, 16'sh8000, S25Min, S25Min, DIR_REV, DIR_FWD);
    send_tick(16'sd0, 16'sd0, 25'sd0, 25'sd0, DIR_FWD, DIR_FWD);
  endtask

  task automatic test_stop_clears();
    drain();
    load_defaults();
    send_tick(16'sd50, -16'sd40, 25'sd150000, 25'sd120000, DIR_FWD, DIR_REV);
    send_tick(16'sd60, -16'sd45, 25'sd150000, 25'sd120000, DIR_FWD, DIR_REV);
    send_tick(16'sd60, -16'sd45, 25'sd150000, 25'sd120000, DIR_STOP, DIR_ALT_STOP);
    send_tick(16'sd20, -16'sd10, 25'sd150000, 25'sd120000, DIR_REV, DIR_FWD);
    send_tick(16'sd20, -16'sd10, -25'sd90000, -25'sd80000, DIR_ALT_STOP, DIR_STOP);
    send_tick(-16'sd30, 16'sd30, -25'sd90000, -25'sd80000, DIR_REV, DIR_REV);
  endtask

  task automatic test_limit_lowered();
    drain();
    load_defaults();
    repeat (3) send_tick(16'sd0, 16'sd0, 25'sd200000, -25'sd200000, DIR_FWD, DIR_REV);
    drain();
    write_reg(CFG_LLIMIT, 24'd1000);
    write_reg(CFG_RLIMIT, 24'd1);
    send_tick(16'sd0, 16'sd0, 25'sd200000, -25'sd200000, DIR_FWD, DIR_REV);
    send_tick(16'sd10, 16'sd10, -25'sd5000, 25'sd5000, DIR_FWD, DIR_FWD);
    drain();
    write_reg(CFG_LLIMIT, 24'd0);
    write_reg(CFG_RLIMIT, 24'd0);
    send_tick(16'sd5, -16'sd5, 25'sd100000, 25'sd100000, DIR_FWD, DIR_FWD);
    send_tick(16'sd5, -16'sd5, -25'sd100000, -25'sd100000, DIR_REV, DIR_REV);
    drain();
    write_reg(CFG_LLIMIT, LimitReset);
    write_reg(CFG_RLIMIT, LimitReset);
  endtask

  task automatic test_random();
    int idle_mode [4];
    int stall_mode [4];
    idle_mode  = '{0, 49, 0, 17};
    stall_mode = '{0, 0, 49, 17};
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        drain();
        randomize_config();
        idle_pct  = idle_mode[m];
        stall_pct = stall_mode[m];
        repeat (ItemsPerSet)
          send_tick(rand_count(), rand_count(), rand_target(), rand_target(),
                    rand_dir(), rand_dir());
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    left_count      = '0;
    right_raw_count = '0;
    left_target     = '0;
    right_target    = '0;
    left_dir        = DIR_STOP;
    right_dir       = DIR_STOP;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_KP;
    cfg_data        = '0;
    kp              = KpReset;
    ki              = KiReset;
    scale           = ScaleReset;
    wheel_limit[0]  = LimitReset;
    wheel_limit[1]  = LimitReset;
    pwm_max         = MaxPwmReset;
    prev_err        = '{0, 0};
    accum           = '{0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_saturation();
    test_stop_clears();
    test_limit_lowered();
    test_random();

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
